// File: rtl/crash_dedup_count_table_core_defines.svh
// assertion macros for the crash dedup count table
`ifndef CRASH_DEDUP_COUNT_TABLE_CORE_DEFINES_SVH
`define CRASH_DEDUP_COUNT_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk with reset disabling
`define CDCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk with reset disabling
`define CDCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cdct_pkg.sv
// package for the crash dedup count table: types, codes and severity lookup
`timescale 1ns / 1ps

package cdct_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int ADDR_W = 64;
	localparam int SIG_W = 7;
	localparam int COUNT_W = 32;
	localparam int SLOT_W = 6;
	localparam int USE_W = 7;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [1:0] OUT_NEW = 2'd0;
	localparam logic [1:0] OUT_COUNTED = 2'd1;
	localparam logic [1:0] OUT_DROPPED = 2'd2;
	localparam logic [1:0] OUT_CLEARED = 2'd3;

	localparam logic [1:0] SEV_LOW = 2'd0;
	localparam logic [1:0] SEV_MEDIUM = 2'd1;
	localparam logic [1:0] SEV_HIGH = 2'd2;
	localparam logic [1:0] SEV_CRITICAL = 2'd3;

	localparam logic [1:0] MAP_GENERIC = 2'd0;
	localparam logic [1:0] MAP_LINUX = 2'd1;
	localparam logic [1:0] MAP_MACOS = 2'd2;

	typedef struct packed {
		logic cmd;
		logic [SIG_W-1:0] signal_number;
		logic [ADDR_W-1:0] fault_address;
	} item_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic [SLOT_W-1:0] entry_slot;
		logic [COUNT_W-1:0] occurrence_count;
		logic [1:0] severity_class;
		logic [USE_W-1:0] entries_in_use;
	} result_t;

	// search token walking down the cell row
	typedef struct packed {
		logic done;
		logic hit;
		logic [IDX_W-1:0] slot;
		logic [COUNT_W-1:0] count;
		logic [ADDR_W-1:0] addr;
		logic [SIG_W-1:0] sig;
	} tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_RESP
	} state_t;

	function automatic logic [1:0] severity_of(input logic [SIG_W-1:0] sig,
		input logic [1:0] map);
		logic [1:0] sev;
		sev = SEV_LOW;
		if (map == MAP_LINUX) begin
			case (sig)
				7'd4, 7'd7, 7'd11: sev = SEV_CRITICAL;
				7'd6, 7'd8, 7'd31: sev = SEV_HIGH;
				7'd3, 7'd5, 7'd13, 7'd16, 7'd24, 7'd25: sev = SEV_MEDIUM;
				default: sev = SEV_LOW;
			endcase
		end else if (map == MAP_MACOS) begin
			case (sig)
				7'd4, 7'd10, 7'd11: sev = SEV_CRITICAL;
				7'd6, 7'd8, 7'd12: sev = SEV_HIGH;
				7'd3, 7'd5, 7'd7, 7'd13, 7'd24, 7'd25: sev = SEV_MEDIUM;
				default: sev = SEV_LOW;
			endcase
		end else begin
			case (sig)
				7'd4, 7'd11: sev = SEV_CRITICAL;
				7'd6, 7'd8: sev = SEV_HIGH;
				7'd3, 7'd5, 7'd13: sev = SEV_MEDIUM;
				default: sev = SEV_LOW;
			endcase
		end
		return sev;
	endfunction

endpackage

// File: rtl/cdct_cell.sv
// one table entry cell: compares, counts or appends as the search token passes
`timescale 1ns / 1ps

module cdct_cell
	import cdct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] used,
	input  logic             tok_in_vld,
	input  tok_t             tok_in,
	output logic             tok_out_vld,
	output tok_t             tok_out
);

	logic [ADDR_W-1:0] addr_q;
	logic [SIG_W-1:0] sig_q;
	logic [COUNT_W-1:0] cnt_q;
	logic tok_vld_q;
	tok_t tok_q;

	logic active;
	logic in_use;
	logic at_end;
	logic match;
	logic [COUNT_W-1:0] cnt_inc;
	tok_t tok_nxt;

	always_comb begin
		active = tok_in_vld && !tok_in.done;
		// a full table counts nothing, so no cell may hit then
		in_use = (CNT_W'(idx) < used) && (used != CNT_W'(TABLE_DEPTH));
		at_end = CNT_W'(idx) == used;
		match = (addr_q == tok_in.addr) && (sig_q == tok_in.sig);
		cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_W'(1);
		tok_nxt = tok_in;
		if (active && in_use && match) begin
			tok_nxt.done = 1'b1;
			tok_nxt.hit = 1'b1;
			tok_nxt.slot = idx;
			tok_nxt.count = cnt_inc;
		end else if (active && at_end) begin
			tok_nxt.done = 1'b1;
			tok_nxt.hit = 1'b0;
			tok_nxt.slot = idx;
			tok_nxt.count = COUNT_W'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (active && in_use && match) begin
			cnt_q <= cnt_inc;
		end else if (active && at_end) begin
			addr_q <= tok_in.addr;
			sig_q <= tok_in.sig;
			cnt_q <= COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign tok_out_vld = tok_vld_q;
	assign tok_out = tok_q;

endmodule

// File: rtl/crash_dedup_count_table_core.sv
// top level of the crash dedup count table: control, severity and cell row
`timescale 1ns / 1ps
`include "crash_dedup_count_table_core_defines.svh"

// Deduplicating fault-event table held in a row of TABLE_DEPTH cells, one
// entry per cell. A record transfer launches a search token that steps one
// cell per clock down the whole row; the first used cell holding the same
// (address, signal) pair counts it, otherwise the cell at the fill level
// takes it as a new entry; a full table drops every record, even a match.
// A record passes the launch register and each cell register before its
// result is registered; a clear goes straight to the result register.
// One item is in flight at a time. The platform mapping selects the signal
// numbering for severity; the user writes it only while idle, not enforced.
module crash_dedup_count_table_core
	import cdct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  item_t      in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    out_data
);

	state_t state_q, state_nxt;
	logic [1:0] map_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] used_inc;
	logic [1:0] sev_q;
	result_t res_q;
	logic launch_vld_q;
	tok_t launch_q;
	logic in_xfer;

	logic tok_vld [0:TABLE_DEPTH];
	tok_t tok [0:TABLE_DEPTH];

	logic end_vld;
	tok_t end_tok;

	assign tok_vld[0] = launch_vld_q;
	assign tok[0] = launch_q;
	assign end_vld = tok_vld[TABLE_DEPTH];
	assign end_tok = tok[TABLE_DEPTH];
	assign used_inc = used_q + CNT_W'(1);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cdct_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (IDX_W'(i)),
			.used        (used_q),
			.tok_in_vld  (tok_vld[i]),
			.tok_in      (tok[i]),
			.tok_out_vld (tok_vld[i+1]),
			.tok_out     (tok[i+1])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_data.cmd == CMD_CLEAR) begin
					state_nxt = ST_RESP;
				end else if (in_valid) begin
					state_nxt = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (end_vld) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_RESP);
		out_data = res_q;
		in_xfer = in_valid && (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			map_q <= MAP_GENERIC;
			used_q <= '0;
			launch_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				map_q <= cfg_wdata;
			end
			if (in_xfer && in_data.cmd == CMD_CLEAR) begin
				used_q <= '0;
			end else if (end_vld && end_tok.done && !end_tok.hit) begin
				used_q <= used_inc;
			end
			launch_vld_q <= in_xfer && (in_data.cmd == CMD_RECORD);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sev_q <= severity_of(in_data.signal_number, map_q);
			launch_q.done <= 1'b0;
			launch_q.hit <= 1'b0;
			launch_q.slot <= '0;
			launch_q.count <= '0;
			launch_q.addr <= in_data.fault_address;
			launch_q.sig <= in_data.signal_number;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (in_xfer && in_data.cmd == CMD_CLEAR) begin
			res_q.outcome <= OUT_CLEARED;
			res_q.entry_slot <= '0;
			res_q.occurrence_count <= '0;
			res_q.severity_class <= SEV_LOW;
			res_q.entries_in_use <= '0;
		end else if (end_vld) begin
			res_q.severity_class <= sev_q;
			if (end_tok.done && end_tok.hit) begin
				res_q.outcome <= OUT_COUNTED;
				res_q.entry_slot <= SLOT_W'(end_tok.slot);
				res_q.occurrence_count <= end_tok.count;
				res_q.entries_in_use <= USE_W'(used_q);
			end else if (end_tok.done) begin
				res_q.outcome <= OUT_NEW;
				res_q.entry_slot <= SLOT_W'(end_tok.slot);
				res_q.occurrence_count <= end_tok.count;
				res_q.entries_in_use <= USE_W'(used_inc);
			end else begin
				res_q.outcome <= OUT_DROPPED;
				res_q.entry_slot <= '0;
				res_q.occurrence_count <= '0;
				res_q.entries_in_use <= USE_W'(used_q);
			end
		end
	end

	`CDCT_ASSERT_NOW(a_used_bound, 1'b1, used_q <= CNT_W'(TABLE_DEPTH), "fill level past depth")
	`CDCT_ASSERT_NOW(a_token_busy, end_vld, state_q == ST_BUSY, "token left row while not searching")
	`CDCT_ASSERT_NEXT(a_append_grows, end_vld && end_tok.done && !end_tok.hit, used_q == $past(used_inc), "append did not grow table")
	`CDCT_ASSERT_NEXT(a_clear_empties, in_xfer && in_data.cmd == CMD_CLEAR, used_q == '0 && out_valid, "clear did not empty table")

endmodule
